>>> rtl/core/ehm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ehm_pkg;

	// Table geometry and field widths
	localparam int unsigned STRIP_CNT = 4096;
	localparam int unsigned HIT_CNT   = 4096;
	localparam int unsigned STRIP_W   = 12;
	localparam int unsigned TIME_W    = 18;
	localparam int unsigned IDX_W     = 12;
	localparam int unsigned CNT_W     = 12;
	localparam int unsigned ADDR_W    = $clog2(STRIP_CNT);
	// Epoch tag kept with every table entry; zero never marks a live entry
	localparam int unsigned EPOCH_W   = 8;

	localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
	localparam logic [STRIP_W:0]   STRIP_LIM = (STRIP_W+1)'(STRIP_CNT);
	localparam logic [IDX_W:0]     IDX_LIM   = (IDX_W+1)'(HIT_CNT);

	// Input item mode codes
	localparam logic MODE_HIT = 1'b0;
	localparam logic MODE_EOE = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [STRIP_W-1:0] strip_id;
		logic [TIME_W-1:0]  hit_time_ps;
		logic [IDX_W-1:0]   hit_index;
	} hit_t;

	typedef struct packed {
		logic [IDX_W-1:0] kept_index;
		logic             dropped_valid;
		logic [IDX_W-1:0] dropped_index;
		logic             event_done;
		logic [CNT_W-1:0] merged_count;
	} result_t;

	typedef enum logic [1:0] {
		CMD_PASS,
		CMD_TABLE,
		CMD_EOE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [ADDR_W-1:0] strip;
		logic [TIME_W-1:0] t;
		logic [IDX_W-1:0]  idx;
	} cmd_t;

	// Status from back end to front end
	typedef struct packed {
		logic clr_busy;
	} back_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/ehm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ehm_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	output logic                full,
	input  ehm_pkg::hit_t       hit,
	input  wire                 merge_en,
	input  ehm_pkg::back_stat_t stat,
	output logic                cmd_valid,
	output ehm_pkg::cmd_t       cmd,
	input  wire                 cmd_pop
);

	ehm_pkg::cmd_t ent_q [2];
	ehm_pkg::cmd_t new_cmd;
	logic [1:0]    cnt_q;
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic          accept;
	logic          in_range;

	assign full      = (cnt_q == 2'd2) || stat.clr_busy;
	assign accept    = push && !full;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = ent_q[rd_ptr_q];

	// Out-of-range strips or indexes bypass the table
	assign in_range = ({1'b0, hit.strip_id} < ehm_pkg::STRIP_LIM) &&
		({1'b0, hit.hit_index} < ehm_pkg::IDX_LIM);

	always_comb begin
		new_cmd.strip = hit.strip_id[ehm_pkg::ADDR_W-1:0];
		new_cmd.t     = hit.hit_time_ps;
		new_cmd.idx   = hit.hit_index;
		if (hit.mode == ehm_pkg::MODE_EOE) begin
			new_cmd.kind = ehm_pkg::CMD_EOE;
		end else if (merge_en && in_range) begin
			new_cmd.kind = ehm_pkg::CMD_TABLE;
		end else begin
			new_cmd.kind = ehm_pkg::CMD_PASS;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (accept) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(accept) - 2'(cmd_pop);
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/ehm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ehm_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cmd_valid,
	input  ehm_pkg::cmd_t        cmd,
	output logic                 cmd_pop,
	output ehm_pkg::back_stat_t  stat,
	output logic                 empty,
	input  wire                  pop,
	output ehm_pkg::result_t     result
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK
	} state_t;

	typedef struct packed {
		logic [ehm_pkg::EPOCH_W-1:0] tag;
		logic [ehm_pkg::TIME_W-1:0]  t;
		logic [ehm_pkg::IDX_W-1:0]   idx;
	} ent_t;

	state_t                      state_q;
	logic [ehm_pkg::ADDR_W-1:0]  clr_addr_q;
	logic [ehm_pkg::EPOCH_W-1:0] epoch_q;
	logic [ehm_pkg::CNT_W-1:0]   cnt_q;
	ehm_pkg::cmd_t               cmd_s1;

	ent_t                        mem [ehm_pkg::STRIP_CNT];
	ent_t                        rd_q;
	logic                        mem_re;
	logic                        mem_we;
	logic [ehm_pkg::ADDR_W-1:0]  mem_wa;
	ent_t                        mem_wd;

	ehm_pkg::result_t            oq_q [2];
	logic [1:0]                  out_cnt_q;
	logic                        o_wr_q;
	logic                        o_rd_q;
	logic                        res_we;
	ehm_pkg::result_t            res_d;
	logic                        deq;

	logic                        take;
	logic                        live;
	logic                        faster;

	assign take    = (state_q == ST_IDLE) && cmd_valid && (out_cnt_q != 2'd2);
	assign cmd_pop = take;
	assign stat.clr_busy = (state_q == ST_CLEAR);

	assign live   = (rd_q.tag == epoch_q);
	assign faster = (cmd_s1.t < rd_q.t);

	assign mem_re = take && (cmd.kind == ehm_pkg::CMD_TABLE);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = cmd_s1.strip;
		mem_wd = '{tag: epoch_q, t: cmd_s1.t, idx: cmd_s1.idx};
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_addr_q;
			mem_wd = '0;
		end else if (state_q == ST_LOOK) begin
			mem_we = !live || faster;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[cmd.strip];
		end
	end

	// Result formation
	always_comb begin
		res_we = 1'b0;
		res_d  = '0;
		if (state_q == ST_LOOK) begin
			res_we = 1'b1;
			if (!live) begin
				res_d.kept_index = cmd_s1.idx;
			end else if (faster) begin
				res_d.kept_index    = cmd_s1.idx;
				res_d.dropped_valid = 1'b1;
				res_d.dropped_index = rd_q.idx;
			end else begin
				res_d.kept_index    = rd_q.idx;
				res_d.dropped_valid = 1'b1;
				res_d.dropped_index = cmd_s1.idx;
			end
		end else if (take) begin
			case (cmd.kind)
				ehm_pkg::CMD_PASS: begin
					res_we           = 1'b1;
					res_d.kept_index = cmd.idx;
				end
				ehm_pkg::CMD_EOE: begin
					res_we             = 1'b1;
					res_d.event_done   = 1'b1;
					res_d.merged_count = cnt_q;
				end
				default: begin
					res_we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd;
		end
		if (res_we) begin
			oq_q[o_wr_q] <= res_d;
		end
	end

	assign empty  = (out_cnt_q == 2'd0);
	assign result = oq_q[o_rd_q];
	assign deq    = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			epoch_q    <= ehm_pkg::EPOCH_W'(1);
			cnt_q      <= '0;
			out_cnt_q  <= 2'd0;
			o_wr_q     <= 1'b0;
			o_rd_q     <= 1'b0;
		end else begin
			if (res_we) begin
				o_wr_q <= !o_wr_q;
			end
			if (deq) begin
				o_rd_q <= !o_rd_q;
			end
			out_cnt_q <= out_cnt_q + 2'(res_we) - 2'(deq);

			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ehm_pkg::ADDR_W'(ehm_pkg::STRIP_CNT - 1)) begin
						state_q <= ST_IDLE;
						epoch_q <= ehm_pkg::EPOCH_W'(1);
					end
				end
				ST_IDLE: begin
					if (take) begin
						case (cmd.kind)
							ehm_pkg::CMD_TABLE: begin
								state_q <= ST_LOOK;
							end
							ehm_pkg::CMD_EOE: begin
								cnt_q <= '0;
								// last epoch used up: wipe the tags
								if (epoch_q == '1) begin
									state_q    <= ST_CLEAR;
									clr_addr_q <= '0;
								end else begin
									epoch_q <= epoch_q + 1'b1;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_LOOK: begin
					state_q <= ST_IDLE;
					if (live && (cnt_q != ehm_pkg::CNT_MAX)) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_no_oq_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_we |-> (out_cnt_q != 2'd2))
		else $error("result queue overflow");

	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !cmd_pop)
		else $error("command taken during table clear");

	a_look_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) |=> (state_q == ST_IDLE))
		else $error("lookup state held");

	a_epoch_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CLEAR) |-> (epoch_q != '0))
		else $error("zero epoch in use");

	a_eoe_clears_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (cmd.kind == ehm_pkg::CMD_EOE)) |=> (cnt_q == '0))
		else $error("merge counter not cleared at end of event");

endmodule

`default_nettype wire

>>> rtl/core/earliest_hit_per_strip_merge_core.sv
// Pass-through and end-of-event items go from the front queue into the result
// queue once the back end takes them; hits that go through the strip table first
// pass a table read, then an update step, and the back end takes no new item until
// that update is done; the single-port table read/write sequence sets this.
// Reset (arst_n low, async): queues empty, merge_enable = 1, then all 4096 table
// entries clear, full high; the same clear runs after every 255th end of event.
`timescale 1ns / 1ps
`default_nettype none

module earliest_hit_per_strip_merge_core (
	input  wire                  clk,
	input  wire                  arst_n,
	// hit items in
	input  wire                  push,
	output logic                 full,
	input  ehm_pkg::hit_t        hit,
	// results out
	output logic                 empty,
	input  wire                  pop,
	output ehm_pkg::result_t     result,
	// merge_enable register write
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire                  cfg_data
);

	// merge_enable: 1 keeps fastest hit per strip, 0 passes every hit through.
	// Sampled at accept time; the user must change it only while the block is idle (not enforced).
	logic merge_en_q;

	ehm_pkg::cmd_t       cmd;
	logic                cmd_valid;
	logic                cmd_pop;
	ehm_pkg::back_stat_t stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_en_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			merge_en_q <= cfg_data;
		end
	end

	// Front end: takes items, tags each as table hit, pass-through or end of
	// event, and holds them in a two-entry queue.
	ehm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.hit       (hit),
		.merge_en  (merge_en_q),
		.stat      (stat),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// Back end: epoch-tagged strip table, merge counter, table clear, and a
	// two-entry result queue so the front keeps taking items while a result
	// waits to be popped.
	ehm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.stat      (stat),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

`default_nettype wire
